// ===== rtl/frdp_pkg.sv =====
// Shared types and constants for the framed ASCII decimal record parser.
package frdp_pkg;

  localparam int HPOS_W = 4;
  localparam int FIDX_W = 5;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_EOR   = 1'b1;

  localparam logic [1:0] REG_HEADER_LENGTH = 2'd0;
  localparam logic [1:0] REG_HEADER_BYTES  = 2'd1;
  localparam logic [1:0] REG_USE_GROUP     = 2'd2;
  localparam logic [1:0] REG_VALUE_COUNT   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_GROUP,
    PH_VALUES,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic [3:0]  header_length;
    logic [63:0] header_bytes;
    logic        use_group;
    logic [4:0]  value_count;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         group_id;
    logic [3:0]         value_index;
    logic signed [31:0] mantissa;
    logic [3:0]         frac_digits;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

// ===== rtl/framed_ascii_decimal_record_parser.sv =====
// Top level: config registers, input byte register, parser and result queue.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_rx_byte
//   out_     output     out_valid / out_ready   kind, group_id, value_index, mantissa,
//                                               frac_digits, last
//   cfg_     input      APB write, pready = 1   64-bit registers at 8*index
//
// One byte per cycle while the queue has room; a byte is held in the input register, then parsed.
// A number ended by newline gives two results and needs two free slots in the
// 4-entry result queue; the parse stage holds its byte until that room exists.
// rst_n is synchronous: parser returns to header search, queue empties, registers
// take their reset values. A stalled output fills the queue past two entries, then in_ready drops.
module framed_ascii_decimal_record_parser #(
  parameter int MAX_HEADER = 8,
  parameter int MAX_VALUES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [7:0]         out_group_id,
  output logic [3:0]         out_value_index,
  output logic signed [31:0] out_mantissa,
  output logic [3:0]         out_frac_digits,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);

  frdp_pkg::cfg_t cfg_r;
  logic           cfg_wr;

  logic       byte_valid_r;
  logic [7:0] byte_r;
  logic       step_en;
  frdp_pkg::step_out_t step_out;

  frdp_pkg::result_t q_mem [frdp_pkg::QDEPTH];
  logic [frdp_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [frdp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic       pop;
  frdp_pkg::result_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_length <= '0;
      cfg_r.header_bytes  <= '0;
      cfg_r.use_group     <= 1'b0;
      cfg_r.value_count   <= 5'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        frdp_pkg::REG_HEADER_LENGTH: cfg_r.header_length <= cfg_pwdata[3:0];
        frdp_pkg::REG_HEADER_BYTES:  cfg_r.header_bytes  <= cfg_pwdata;
        frdp_pkg::REG_USE_GROUP:     cfg_r.use_group     <= cfg_pwdata[0];
        frdp_pkg::REG_VALUE_COUNT:   cfg_r.value_count   <= cfg_pwdata[4:0];
        default: cfg_r.value_count <= cfg_r.value_count;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      frdp_pkg::REG_HEADER_LENGTH: cfg_prdata = {60'd0, cfg_r.header_length};
      frdp_pkg::REG_HEADER_BYTES:  cfg_prdata = cfg_r.header_bytes;
      frdp_pkg::REG_USE_GROUP:     cfg_prdata = {63'd0, cfg_r.use_group};
      frdp_pkg::REG_VALUE_COUNT:   cfg_prdata = {59'd0, cfg_r.value_count};
      default:                     cfg_prdata = '0;
    endcase
  end

  // parse stage runs when the queue has room for two results
  assign step_en  = byte_valid_r && (cnt_r <= frdp_pkg::QCNT_W'(frdp_pkg::QDEPTH - 2));
  assign in_ready = !byte_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  frdp_parser #(
    .MAX_HEADER(MAX_HEADER),
    .MAX_VALUES(MAX_VALUES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step_en  (step_en),
    .rx_byte  (byte_r),
    .step_out (step_out)
  );

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign q_head    = q_mem[rd_ptr_r];

  assign out_kind        = q_head.kind;
  assign out_group_id    = q_head.group_id;
  assign out_value_index = q_head.value_index;
  assign out_mantissa    = q_head.mantissa;
  assign out_frac_digits = q_head.frac_digits;
  assign out_last        = q_head.last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (step_en) cnt_nxt = cnt_nxt + frdp_pkg::QCNT_W'(step_out.count);
    if (pop)     cnt_nxt = cnt_nxt - frdp_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) rd_ptr_r <= rd_ptr_r + frdp_pkg::QPTR_W'(1);
      if (step_en) wr_ptr_r <= wr_ptr_r + frdp_pkg::QPTR_W'(step_out.count);
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && (step_out.count != 2'd0)) begin
      q_mem[wr_ptr_r] <= step_out.res0;
    end
    if (step_en && (step_out.count == 2'd2)) begin
      q_mem[wr_ptr_r + frdp_pkg::QPTR_W'(1)] <= step_out.res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= frdp_pkg::QCNT_W'(frdp_pkg::QDEPTH))
    else $error("result queue overflow");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (step_out.count == 2'd1)) |-> step_out.res0.last)
    else $error("single result not marked last");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (step_out.count == 2'd2)) |->
      (!step_out.res0.last && step_out.res1.last &&
       (step_out.res0.kind == frdp_pkg::KIND_VALUE) &&
       (step_out.res1.kind == frdp_pkg::KIND_EOR)))
    else $error("two-result transaction out of order");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    frdp_pkg::QPTR_W'(wr_ptr_r - rd_ptr_r) == frdp_pkg::QPTR_W'(cnt_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== rtl/frdp_parser.sv =====
// Per-byte parse step: header match, group byte, decimal values, record end.
module frdp_parser #(
  parameter int MAX_HEADER = 8,
  parameter int MAX_VALUES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  frdp_pkg::cfg_t      cfg,
  input  logic                step_en,
  input  logic [7:0]          rx_byte,
  output frdp_pkg::step_out_t step_out
);

  frdp_pkg::phase_t phase_r, phase_nxt;
  logic [frdp_pkg::HPOS_W-1:0] header_pos_r, header_pos_nxt;
  logic [frdp_pkg::FIDX_W-1:0] field_index_r, field_index_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [3:0]  frac_count_r, frac_count_nxt;
  logic        in_number_r, in_number_nxt;
  logic        point_seen_r, point_seen_nxt;
  logic        negative_r, negative_nxt;
  logic [7:0]  group_r, group_nxt;

  logic [3:0] hl;
  logic [frdp_pkg::FIDX_W-1:0] vc_clamp, vc;
  logic       hdr_active, hdr_match, hdr_done, start_now;
  logic [7:0] hdr_byte;
  frdp_pkg::phase_t work_phase, rec_phase;

  logic [frdp_pkg::FIDX_W-1:0] fi_cur, fi_inc;
  logic [31:0] acc_cur, acc_x10, mant;
  logic [3:0]  frac_cur, digit_val;
  logic        in_num_cur, point_cur, neg_cur;
  logic [7:0]  group_cur;
  logic        is_digit, is_point, is_minus, is_nl, num_end;

  assign hl = (32'(cfg.header_length) > MAX_HEADER) ? 4'(MAX_HEADER) : cfg.header_length;
  assign vc_clamp = (32'(cfg.value_count) > MAX_VALUES) ? frdp_pkg::FIDX_W'(MAX_VALUES)
                                                        : cfg.value_count;
  assign vc = (cfg.value_count == '0) ? frdp_pkg::FIDX_W'(1) : vc_clamp;

  assign hdr_active = (phase_r == frdp_pkg::PH_HEADER) && (header_pos_r < hl);
  assign hdr_byte   = cfg.header_bytes[{header_pos_r[2:0], 3'b000} +: 8];
  assign hdr_match  = (rx_byte == hdr_byte);
  assign hdr_done   = hdr_match && ((5'(header_pos_r) + 5'd1) >= {1'b0, hl});
  assign start_now  = (phase_r == frdp_pkg::PH_HEADER) && !hdr_active;
  assign rec_phase  = cfg.use_group ? frdp_pkg::PH_GROUP : frdp_pkg::PH_VALUES;
  assign work_phase = start_now ? rec_phase : phase_r;

  // record start clears the number and record state before the byte is used
  assign fi_cur     = start_now ? '0 : field_index_r;
  assign acc_cur    = start_now ? '0 : accum_r;
  assign frac_cur   = start_now ? '0 : frac_count_r;
  assign in_num_cur = start_now ? 1'b0 : in_number_r;
  assign point_cur  = start_now ? 1'b0 : point_seen_r;
  assign neg_cur    = start_now ? 1'b0 : negative_r;
  assign group_cur  = start_now ? '0 : group_r;

  assign is_digit  = (rx_byte >= frdp_pkg::CH_ZERO) && (rx_byte <= frdp_pkg::CH_NINE);
  assign is_point  = (rx_byte == frdp_pkg::CH_POINT);
  assign is_minus  = (rx_byte == frdp_pkg::CH_MINUS);
  assign is_nl     = (rx_byte == frdp_pkg::CH_NL);
  assign num_end   = in_num_cur && !is_digit && !is_point;
  assign digit_val = 4'(rx_byte - frdp_pkg::CH_ZERO);
  assign acc_x10   = (acc_cur << 3) + (acc_cur << 1);
  assign mant      = neg_cur ? (32'd0 - acc_cur) : acc_cur;
  assign fi_inc    = fi_cur + frdp_pkg::FIDX_W'(1);

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    header_pos_nxt = header_pos_r;
    if (hdr_active) begin
      if (hdr_match) begin
        header_pos_nxt = header_pos_r + 4'd1;
        if (hdr_done) begin
          header_pos_nxt = '0;
          phase_nxt      = rec_phase;
        end
      end else begin
        header_pos_nxt = '0;
      end
    end else begin
      header_pos_nxt = '0;
      unique case (work_phase)
        frdp_pkg::PH_HEADER: phase_nxt = frdp_pkg::PH_HEADER;
        frdp_pkg::PH_GROUP:  phase_nxt = frdp_pkg::PH_VALUES;
        frdp_pkg::PH_VALUES: begin
          phase_nxt = frdp_pkg::PH_VALUES;
          if (num_end) begin
            if (fi_inc >= vc) phase_nxt = frdp_pkg::PH_WAIT;
            if (is_nl) phase_nxt = frdp_pkg::PH_HEADER;
          end
        end
        frdp_pkg::PH_WAIT: begin
          phase_nxt = is_nl ? frdp_pkg::PH_HEADER : frdp_pkg::PH_WAIT;
        end
        default: phase_nxt = frdp_pkg::PH_HEADER;
      endcase
    end
  end

  // outputs and number datapath
  always_comb begin
    field_index_nxt = field_index_r;
    accum_nxt       = accum_r;
    frac_count_nxt  = frac_count_r;
    in_number_nxt   = in_number_r;
    point_seen_nxt  = point_seen_r;
    negative_nxt    = negative_r;
    group_nxt       = group_r;
    step_out        = '0;
    if (hdr_active) begin
      if (hdr_done) begin
        field_index_nxt = '0;
        accum_nxt       = '0;
        frac_count_nxt  = '0;
        in_number_nxt   = 1'b0;
        point_seen_nxt  = 1'b0;
        negative_nxt    = 1'b0;
        group_nxt       = '0;
      end
    end else begin
      field_index_nxt = fi_cur;
      accum_nxt       = acc_cur;
      frac_count_nxt  = frac_cur;
      in_number_nxt   = in_num_cur;
      point_seen_nxt  = point_cur;
      negative_nxt    = neg_cur;
      group_nxt       = group_cur;
      unique case (work_phase)
        frdp_pkg::PH_GROUP: group_nxt = rx_byte;
        frdp_pkg::PH_VALUES: begin
          if (in_num_cur) begin
            if (is_digit) begin
              accum_nxt = acc_x10 + 32'(digit_val);
              if (point_cur && (frac_cur != 4'd15)) frac_count_nxt = frac_cur + 4'd1;
            end else if (is_point) begin
              point_seen_nxt = 1'b1;
            end else begin
              step_out.res0.kind        = frdp_pkg::KIND_VALUE;
              step_out.res0.group_id    = group_cur;
              step_out.res0.value_index = fi_cur[3:0];
              step_out.res0.mantissa    = mant;
              step_out.res0.frac_digits = frac_cur;
              accum_nxt       = '0;
              frac_count_nxt  = '0;
              in_number_nxt   = 1'b0;
              point_seen_nxt  = 1'b0;
              negative_nxt    = 1'b0;
              field_index_nxt = fi_inc;
              if (is_nl) begin
                step_out.res1.kind     = frdp_pkg::KIND_EOR;
                step_out.res1.group_id = group_cur;
                step_out.res1.last     = 1'b1;
                step_out.count         = 2'd2;
              end else begin
                step_out.res0.last = 1'b1;
                step_out.count     = 2'd1;
              end
            end
          end else begin
            if (is_digit) begin
              in_number_nxt = 1'b1;
              accum_nxt     = 32'(digit_val);
            end else if (is_point) begin
              in_number_nxt  = 1'b1;
              point_seen_nxt = 1'b1;
              accum_nxt      = '0;
            end else if (is_minus) begin
              negative_nxt = 1'b1;
            end
          end
        end
        frdp_pkg::PH_WAIT: begin
          if (is_nl) begin
            step_out.res0.kind     = frdp_pkg::KIND_EOR;
            step_out.res0.group_id = group_cur;
            step_out.res0.last     = 1'b1;
            step_out.count         = 2'd1;
          end
        end
        frdp_pkg::PH_HEADER: group_nxt = group_cur;
        default: group_nxt = group_cur;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= frdp_pkg::PH_HEADER;
      header_pos_r  <= '0;
      field_index_r <= '0;
      accum_r       <= '0;
      frac_count_r  <= '0;
      in_number_r   <= 1'b0;
      point_seen_r  <= 1'b0;
      negative_r    <= 1'b0;
      group_r       <= '0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      header_pos_r  <= header_pos_nxt;
      field_index_r <= field_index_nxt;
      accum_r       <= accum_nxt;
      frac_count_r  <= frac_count_nxt;
      in_number_r   <= in_number_nxt;
      point_seen_r  <= point_seen_nxt;
      negative_r    <= negative_nxt;
      group_r       <= group_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the framed ASCII decimal record parser.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1900;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TAB   = 8'h09;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [7:0]         out_group_id;
  logic [3:0]         out_value_index;
  logic signed [31:0] out_mantissa;
  logic [3:0]         out_frac_digits;
  logic               out_last;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [4:0]         cfg_paddr;
  logic [63:0]        cfg_pwdata;
  logic [63:0]        cfg_prdata;
  logic               cfg_pready;

  // expected parser state and register copies
  frdp_pkg::phase_t parse_phase;
  logic [3:0]  hdr_pos;
  logic [4:0]  fld_idx;
  logic [31:0] acc;
  logic [3:0]  frac_cnt;
  bit          in_num;
  bit          pt_seen;
  bit          neg;
  logic [7:0]  rec_group;
  logic [3:0]  cf_hlen;
  logic [63:0] cf_hbytes;
  bit          cf_group;
  logic [4:0]  cf_vcount;

  frdp_pkg::result_t pending_results[$];
  int      errors;
  int      cycle_count;
  int      bytes_sent;
  int      noise_bytes;
  int      hold_cycles;
  bit      calm;

  framed_ascii_decimal_record_parser u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_group_id    (out_group_id),
    .out_value_index (out_value_index),
    .out_mantissa    (out_mantissa),
    .out_frac_digits (out_frac_digits),
    .out_last        (out_last),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_number();
    acc = '0;
    frac_cnt = '0;
    in_num = 1'b0;
    pt_seen = 1'b0;
    neg = 1'b0;
  endfunction

  function automatic void start_record();
    hdr_pos = '0;
    fld_idx = '0;
    rec_group = '0;
    clear_number();
    parse_phase = cf_group ? frdp_pkg::PH_GROUP : frdp_pkg::PH_VALUES;
  endfunction

  function automatic frdp_pkg::result_t make_result(logic kind, logic [4:0] idx,
                                                    logic [31:0] mant, logic [3:0] frac);
    frdp_pkg::result_t r;
    r.kind = kind;
    r.group_id = rec_group;
    r.value_index = idx[3:0];
    r.mantissa = mant;
    r.frac_digits = frac;
    r.last = 1'b0;
    return r;
  endfunction

  // advances the expected parser by one byte and queues the results it causes
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned       hl;
    int unsigned       vc;
    frdp_pkg::result_t res[2];
    int                n;
    bit                is_digit;
    hl = (cf_hlen > 4'd8) ? 8 : cf_hlen;
    vc = (cf_vcount == 0) ? 1 : ((cf_vcount > 5'd16) ? 16 : cf_vcount);
    n = 0;
    is_digit = (b >= frdp_pkg::CH_ZERO) && (b <= frdp_pkg::CH_NINE);
    if (parse_phase == frdp_pkg::PH_HEADER) begin
      if (hdr_pos < hl) begin
        if (b == cf_hbytes[{hdr_pos[2:0], 3'b000} +: 8]) begin
          hdr_pos++;
          if (hdr_pos >= hl) start_record();
        end else begin
          hdr_pos = '0;
        end
        return;
      end
      start_record();
    end
    case (parse_phase)
      frdp_pkg::PH_GROUP: begin
        rec_group = b;
        parse_phase = frdp_pkg::PH_VALUES;
      end
      frdp_pkg::PH_VALUES: begin
        if (in_num) begin
          if (is_digit) begin
            acc = acc * 32'd10 + 32'(b - frdp_pkg::CH_ZERO);
            if (pt_seen && frac_cnt < 4'd15) frac_cnt++;
          end else if (b == frdp_pkg::CH_POINT) begin
            pt_seen = 1'b1;
          end else begin
            res[n] = make_result(frdp_pkg::KIND_VALUE, fld_idx, neg ? -acc : acc, frac_cnt);
            n++;
            clear_number();
            fld_idx++;
            if (fld_idx >= vc) parse_phase = frdp_pkg::PH_WAIT;
            if (b == frdp_pkg::CH_NL) begin
              res[n] = make_result(frdp_pkg::KIND_EOR, 5'd0, 32'd0, 4'd0);
              n++;
              parse_phase = frdp_pkg::PH_HEADER;
              hdr_pos = '0;
            end
          end
        end else begin
          if (is_digit) begin
            in_num = 1'b1;
            acc = 32'(b - frdp_pkg::CH_ZERO);
          end else if (b == frdp_pkg::CH_POINT) begin
            in_num = 1'b1;
            pt_seen = 1'b1;
            acc = '0;
          end else if (b == frdp_pkg::CH_MINUS) begin
            neg = 1'b1;
          end
        end
      end
      frdp_pkg::PH_WAIT: begin
        if (b == frdp_pkg::CH_NL) begin
          res[n] = make_result(frdp_pkg::KIND_EOR, 5'd0, 32'd0, 4'd0);
          n++;
          parse_phase = frdp_pkg::PH_HEADER;
          hdr_pos = '0;
        end
      end
      default: begin
        parse_phase = frdp_pkg::PH_HEADER;
        hdr_pos = '0;
      end
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : result_check
    frdp_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual kind=%0d mantissa=%0d",
                 $time, out_kind, out_mantissa);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) report_field("kind", want.kind, out_kind);
        if (out_group_id !== want.group_id)
          report_field("group_id", want.group_id, out_group_id);
        if (out_value_index !== want.value_index)
          report_field("value_index", want.value_index, out_value_index);
        if (out_mantissa !== want.mantissa)
          report_field("mantissa", want.mantissa, out_mantissa);
        if (out_frac_digits !== want.frac_digits)
          report_field("frac_digits", want.frac_digits, out_frac_digits);
        if (out_last !== want.last) report_field("last", want.last, out_last);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = idle_length() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)));
      noise_bytes++;
    end
  endtask

  // sender pauses until every expected transaction is back, then lets the pipe drain
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      frdp_pkg::REG_HEADER_LENGTH: cf_hlen = val[3:0];
      frdp_pkg::REG_HEADER_BYTES:  cf_hbytes = val;
      frdp_pkg::REG_USE_GROUP:     cf_group = val[0];
      frdp_pkg::REG_VALUE_COUNT:   cf_vcount = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] hlen, input logic [63:0] hbytes,
                            input bit grp, input logic [4:0] vcount);
    write_reg(frdp_pkg::REG_HEADER_LENGTH, 64'(hlen));
    write_reg(frdp_pkg::REG_HEADER_BYTES, hbytes);
    write_reg(frdp_pkg::REG_USE_GROUP, 64'(grp));
    write_reg(frdp_pkg::REG_VALUE_COUNT, 64'(vcount));
  endtask

  function automatic logic [7:0] pick_separator();
    int r;
    logic [7:0] s;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2: s = CH_COMMA;
      3, 4:    s = CH_SPACE;
      5:       s = CH_SEMI;
      6:       s = CH_TAB;
      7:       s = frdp_pkg::CH_MINUS;
      default: begin
        s = 8'($urandom_range(0, 255));
        while ((s >= frdp_pkg::CH_ZERO && s <= frdp_pkg::CH_NINE) ||
               s == frdp_pkg::CH_POINT)
          s = 8'($urandom_range(0, 255));
      end
    endcase
    return s;
  endfunction

  task automatic send_number(input logic [7:0] sep);
    int nd;
    int pt_at;
    nd = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
    pt_at = $urandom_range(0, nd + 2);
    if ($urandom_range(0, 2) == 0) send_byte(frdp_pkg::CH_MINUS);
    for (int d = 0; d < nd; d++) begin
      if (d == pt_at) send_byte(frdp_pkg::CH_POINT);
      send_byte(8'(frdp_pkg::CH_ZERO + $urandom_range(0, 9)));
      if (d == pt_at && $urandom_range(0, 7) == 0) send_byte(frdp_pkg::CH_POINT);
    end
    if (pt_at == nd) send_byte(frdp_pkg::CH_POINT);
    send_byte(sep);
  endtask

  // mostly well-formed records; some broken headers, noise, and short or long records
  task automatic send_record();
    int hl;
    int vc;
    int nvals;
    int k;
    logic [7:0] sep;
    logic [7:0] junk;
    hl = (cf_hlen > 4'd8) ? 8 : int'(cf_hlen);
    vc = (cf_vcount == 0) ? 1 : ((cf_vcount > 5'd16) ? 16 : int'(cf_vcount));
    if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4));
    if (hl > 0 && $urandom_range(0, 4) == 0) begin
      k = $urandom_range(0, hl - 1);
      for (int i = 0; i < k; i++) send_byte(cf_hbytes[8*i +: 8]);
      send_byte(cf_hbytes[8*k +: 8] ^ 8'($urandom_range(1, 255)));
    end
    for (int i = 0; i < hl; i++) send_byte(cf_hbytes[8*i +: 8]);
    if (cf_group) send_byte(8'($urandom_range(0, 255)));
    nvals = ($urandom_range(0, 4) != 0) ? vc : $urandom_range(1, vc + 2);
    sep = CH_COMMA;
    for (int v = 0; v < nvals; v++) begin
      if (v == nvals - 1) sep = ($urandom_range(0, 1) == 0) ? frdp_pkg::CH_NL : CH_COMMA;
      else sep = pick_separator();
      send_number(sep);
    end
    if (sep != frdp_pkg::CH_NL) begin
      if ($urandom_range(0, 3) == 0) begin
        junk = 8'($urandom_range(0, 255));
        if (junk == frdp_pkg::CH_NL) junk = CH_SPACE;
        send_byte(junk);
      end
      send_byte(frdp_pkg::CH_NL);
    end
  endtask

  task automatic test_defaults();
    send_text("-0\n");
    wait_drained();
  endtask

  task automatic test_header_group();
    set_config(4'd2, 64'hFFFF_FFFF_FFFF_2324, 1'b1, 5'd2);
    send_text("$X$#");
    send_byte(8'hFF);
    send_text(".5.7-12\n");
    wait_drained();
  endtask

  task automatic test_long_header();
    set_config(4'd15, 64'd0, 1'b0, 5'd0);
    repeat (8) send_byte(8'h00);
    send_text("9\n");
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_config(4'd0, 64'd0, 1'b0, 5'd16);
    hold_cycles = 200;
    for (int i = 0; i < 16; i++) begin
      send_byte(8'(frdp_pkg::CH_ZERO + i % 10));
      send_byte(CH_COMMA);
    end
    send_byte(frdp_pkg::CH_NL);
    wait_drained();
  endtask

  task automatic test_random_records();
    int phase_no;
    int rec_total;
    int base;
    phase_no = 0;
    base = bytes_sent - noise_bytes;
    while (bytes_sent - noise_bytes - base < RANDOM_ITEMS) begin
      case (phase_no)
        0: set_config(4'd0, 64'd0, 1'b0, 5'd1);
        1: set_config(4'd8, '1, 1'b1, 5'd16);
        2: set_config(4'd15, {$urandom, $urandom}, 1'b0, 5'd31);
        3: set_config(4'd1, 64'd0, 1'b1, 5'd0);
        default: set_config(4'($urandom_range(0, 9)), {$urandom, $urandom},
                            1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
      endcase
      calm = ($urandom_range(0, 4) == 0);
      rec_total = $urandom_range(4, 12);
      for (int r = 0; r < rec_total && bytes_sent - noise_bytes - base < RANDOM_ITEMS; r++)
        send_record();
      calm = 1'b0;
      wait_drained();
      phase_no++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    calm = 1'b0;
    hold_cycles = 0;
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    noise_bytes = 0;
    parse_phase = frdp_pkg::PH_HEADER;
    hdr_pos = '0;
    fld_idx = '0;
    rec_group = '0;
    clear_number();
    cf_hlen = 4'd0;
    cf_hbytes = 64'd0;
    cf_group = 1'b0;
    cf_vcount = 5'd1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_header_group();
    test_long_header();
    test_backpressure();
    test_random_records();
    wait_drained();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
